FILE: hdl/sre_pkg.sv
`timescale 1ns / 1ps

package sre_pkg;

	localparam int MAX_SAMPLES_DEF = 64;
	localparam int SAMPLE_W        = 32;
	localparam int RANK_W          = 6;

	// word travelling down the row of cells
	typedef struct packed {
		logic                       valid;
		logic signed [SAMPLE_W-1:0] sample;
		logic [RANK_W-1:0]          below;
	} token_t;

	// rank handed toward the head of the row while draining
	typedef struct packed {
		logic              occ;
		logic [RANK_W-1:0] rank;
	} shift_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_WAIT,
		ST_DRAIN
	} state_t;

endpackage

FILE: hdl/sre_cell.sv
`timescale 1ns / 1ps

module sre_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  sre_pkg::token_t tok_in,
	output sre_pkg::token_t tok_out,
	input  logic            shift,
	input  sre_pkg::shift_t sh_in,
	output sre_pkg::shift_t sh_out
);

	logic                                occ_q;
	logic signed [sre_pkg::SAMPLE_W-1:0] samp_q;
	logic [sre_pkg::RANK_W-1:0]          rank_q;
	sre_pkg::token_t                     tok_q;
	logic                                greater;
	logic                                store;

	// held sample ranks above the passing one only when strictly greater
	assign greater = tok_in.valid && occ_q && (samp_q > tok_in.sample);
	assign store   = tok_in.valid && !occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			tok_q <= '0;
		end else begin
			tok_q.valid  <= tok_in.valid && occ_q;
			tok_q.sample <= tok_in.sample;
			tok_q.below  <= greater ? tok_in.below : tok_in.below + sre_pkg::RANK_W'(1);
			if (shift) begin
				occ_q <= sh_in.occ;
			end else if (store) begin
				occ_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			samp_q <= tok_in.sample;
		end
		if (shift) begin
			rank_q <= sh_in.rank;
		end else if (store) begin
			rank_q <= tok_in.below;
		end else if (greater) begin
			rank_q <= rank_q + sre_pkg::RANK_W'(1);
		end
	end

	assign tok_out     = tok_q;
	assign sh_out.occ  = occ_q;
	assign sh_out.rank = rank_q;

endmodule

FILE: hdl/sample_rank_engine.sv
`timescale 1ns / 1ps
// sample_rank_engine: stable ascending rank of a column of up to MAX_SAMPLES samples
// throughput: one sample per cycle while a column loads (busy low)
// a word walks the cell row one cell per cycle, so after the last sample of a column
// the block is busy until that word reaches its cell, then gives one rank per cycle,
// one per sample; ranks cannot be stalled; busy falls the cycle after the final rank
// reset (arst_n low, asynchronous) empties all cells and returns to loading
module sample_rank_engine #(
	parameter int MAX_SAMPLES = sre_pkg::MAX_SAMPLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [sre_pkg::SAMPLE_W-1:0] sample,
	input  logic                                final_sample,
	output logic                                rank_valid,
	output logic [sre_pkg::RANK_W-1:0]          sample_rank,
	output logic                                final_rank
);

	localparam int POS_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

	sre_pkg::state_t state_q, state_d;
	logic [POS_W-1:0] cnt_q;
	logic [POS_W-1:0] wait_q;
	logic [POS_W-1:0] left_q;
	logic             accept;
	logic             col_end;
	logic             shift;
	sre_pkg::token_t  in_s1;
	sre_pkg::token_t  tok   [MAX_SAMPLES];
	sre_pkg::token_t  tok_end;
	sre_pkg::shift_t  sh    [MAX_SAMPLES+1];

	assign accept  = start && !busy;
	// a column also ends when the store fills
	assign col_end = final_sample || (cnt_q == POS_W'(MAX_SAMPLES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sre_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		busy       = 1'b1;
		shift      = 1'b0;
		rank_valid = 1'b0;
		final_rank = 1'b0;
		unique case (state_q)
			sre_pkg::ST_LOAD: begin
				busy = 1'b0;
				if (accept && col_end) begin
					state_d = sre_pkg::ST_WAIT;
				end
			end
			sre_pkg::ST_WAIT: begin
				if (wait_q == '0) begin
					state_d = sre_pkg::ST_DRAIN;
				end
			end
			sre_pkg::ST_DRAIN: begin
				shift      = 1'b1;
				rank_valid = 1'b1;
				final_rank = (left_q == '0);
				if (left_q == '0) begin
					state_d = sre_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = sre_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			wait_q <= '0;
			left_q <= '0;
			in_s1  <= '0;
		end else begin
			in_s1.valid  <= accept;
			in_s1.sample <= sample;
			in_s1.below  <= '0;
			if (accept) begin
				if (col_end) begin
					cnt_q  <= '0;
					wait_q <= cnt_q;
					left_q <= cnt_q;
				end else begin
					cnt_q <= cnt_q + POS_W'(1);
				end
			end
			if (state_q == sre_pkg::ST_WAIT && wait_q != '0) begin
				wait_q <= wait_q - POS_W'(1);
			end
			if (shift && left_q != '0) begin
				left_q <= left_q - POS_W'(1);
			end
		end
	end

	assign tok[0]           = in_s1;
	assign sh[MAX_SAMPLES]  = '0;

	for (genvar k = 0; k < MAX_SAMPLES; k++) begin : g_cell
		sre_pkg::token_t tok_o;

		sre_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (tok[k]),
			.tok_out(tok_o),
			.shift  (shift),
			.sh_in  (sh[k+1]),
			.sh_out (sh[k])
		);

		if (k < MAX_SAMPLES - 1) begin : g_link
			assign tok[k+1] = tok_o;
		end else begin : g_tail
			assign tok_end = tok_o;
		end
	end

	assign sample_rank = sh[0].rank;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!tok_end.valid)
		else $error("word passed the end of the cell row");

	a_head_full: assert property (@(posedge clk) disable iff (!arst_n)
		rank_valid |-> sh[0].occ)
		else $error("rank given from an empty cell");

	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && col_end |=> busy)
		else $error("column end did not raise busy");

	a_final_free: assert property (@(posedge clk) disable iff (!arst_n)
		rank_valid && final_rank |=> !busy && !sh[0].occ)
		else $error("cells not empty after final rank");

	a_final_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		final_rank |-> rank_valid)
		else $error("final_rank without rank_valid");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	import sre_pkg::*;

	localparam int COL_MAX    = MAX_SAMPLES_DEF;
	localparam int PLAN_LEN   = 16;
	localparam int PHASE_LEN  = 80;
	localparam int QUIET_MAX  = 5000;
	localparam int DRAIN_WAIT = 2 * COL_MAX + 8;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                last;
		logic                known;
		logic [RANK_W-1:0]   rank;
	} plan_row_t;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic              last;
	} rank_word_t;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       final_sample;
	logic                       rank_valid;
	logic [RANK_W-1:0]          sample_rank;
	logic                       final_rank;

	// columns with ranks that can be read off directly; known rows carry their rank
	plan_row_t plan [0:PLAN_LEN-1] = '{
		'{32'h8000_0000, 1'b1, 1'b1, 6'd0},
		'{32'h7fff_ffff, 1'b0, 1'b1, 6'd2},
		'{32'h8000_0000, 1'b0, 1'b1, 6'd0},
		'{32'h0000_0000, 1'b1, 1'b1, 6'd1},
		'{32'h0000_0005, 1'b0, 1'b1, 6'd0},
		'{32'h0000_0005, 1'b0, 1'b1, 6'd1},
		'{32'h0000_0005, 1'b1, 1'b1, 6'd2},
		'{32'h0000_0003, 1'b0, 1'b1, 6'd2},
		'{32'h0000_0002, 1'b0, 1'b1, 6'd1},
		'{32'h0000_0001, 1'b1, 1'b1, 6'd0},
		'{32'hffff_ffff, 1'b0, 1'b1, 6'd0},
		'{32'h0000_0001, 1'b1, 1'b1, 6'd1},
		'{32'h7fff_fffe, 1'b0, 1'b1, 6'd1},
		'{32'h8000_0001, 1'b1, 1'b1, 6'd0},
		'{32'hffff_fff9, 1'b0, 1'b1, 6'd0},
		'{32'hffff_fff9, 1'b1, 1'b1, 6'd1}
	};

	// column being loaded, as the block should hold it
	logic signed [SAMPLE_W-1:0] col_values [COL_MAX];
	logic [RANK_W-1:0]          col_ranks [COL_MAX];
	int                         col_pins [COL_MAX];
	int                         col_fill;

	rank_word_t rank_due [$];
	rank_word_t rank_head;
	int         mismatches;
	int         idle_pct;
	int         quiet_cycles;
	int         sent;

	sample_rank_engine uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.sample       (sample),
		.final_sample (final_sample),
		.rank_valid   (rank_valid),
		.sample_rank  (sample_rank),
		.final_rank   (final_rank)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// stable rank update for one accepted word; closes the column on last or full
	task automatic rank_sample(input logic signed [SAMPLE_W-1:0] value, input logic last,
			input int pin);
		int below;
		rank_word_t w;
		below = 0;
		for (int i = 0; i < col_fill; i++) begin
			if (col_values[i] > value)
				col_ranks[i] = col_ranks[i] + 1'b1;
			else
				below++;
		end
		col_values[col_fill] = value;
		col_ranks[col_fill] = below[RANK_W-1:0];
		col_pins[col_fill] = pin;
		col_fill++;
		if (col_fill == COL_MAX)
			last = 1'b1;
		if (last) begin
			for (int i = 0; i < col_fill; i++) begin
				w.rank = (col_pins[i] >= 0) ? col_pins[i][RANK_W-1:0] : col_ranks[i];
				w.last = (i == col_fill - 1);
				rank_due.push_back(w);
			end
			col_fill = 0;
		end
	endtask

	task automatic send_word(input logic [SAMPLE_W-1:0] value, input logic last,
			input int pin);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		sample <= value;
		final_sample <= last;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		rank_sample(value, last, pin);
		sent++;
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample(input int spread);
		logic [SAMPLE_W-1:0] v;
		if (spread == 1)
			return SAMPLE_W'($signed($urandom_range(6)) - 3);
		case ($urandom_range(9))
			0, 1, 2, 3, 4: v = $urandom;
			5: v = {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
			6: v = {1'b0, {(SAMPLE_W-1){1'b1}}} - $urandom_range(3);
			7: v = {1'b1, {(SAMPLE_W-1){1'b0}}} + $urandom_range(3);
			default: v = SAMPLE_W'($signed($urandom_range(8)) - 4);
		endcase
		return v;
	endfunction

	task automatic run_column(input int len, input int spread);
		logic last;
		for (int i = 0; i < len; i++) begin
			if (i != len - 1)
				last = 1'b0;
			else if (len == COL_MAX)
				last = $urandom_range(1); // a full column closes with or without the flag
			else
				last = 1'b1;
			send_word(pick_sample(spread), last, -1);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rank_valid === 1'b1) begin
			if (rank_due.size() == 0) begin
				report_mismatch("unexpected rank word, rank", sample_rank, 0);
			end else begin
				rank_head = rank_due.pop_front();
				if (sample_rank !== rank_head.rank)
					report_mismatch("sample_rank", sample_rank, rank_head.rank);
				if (final_rank !== rank_head.last)
					report_mismatch("final_rank", final_rank, rank_head.last);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || rank_valid === 1'b1)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int len;
		int pct [4];
		mismatches = 0;
		quiet_cycles = 0;
		col_fill = 0;
		sent = 0;
		idle_pct = 0;
		pct = '{0, 61, 0, 30};
		arst_n <= 1'b0;
		start <= 1'b0;
		sample <= '0;
		final_sample <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < PLAN_LEN; r++)
			send_word(plan[r].value, plan[r].last, plan[r].known ? int'(plan[r].rank) : -1);

		// full column of equal values, closed by the fill alone
		for (int i = 0; i < COL_MAX; i++)
			send_word(32'h0001_8000, 1'b0, i);

		for (int p = 0; p < 4; p++) begin
			idle_pct = pct[p];
			sent = 0;
			while (sent < PHASE_LEN) begin
				len = $urandom_range(99);
				if (len < 70)
					len = $urandom_range(1, 8);
				else if (len < 90)
					len = $urandom_range(9, COL_MAX - 1);
				else
					len = COL_MAX;
				run_column(len, ($urandom_range(3) == 0) ? 1 : 0);
			end
		end
		start <= 1'b0;

		while (rank_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: files.f
hdl/sre_pkg.sv
hdl/sre_cell.sv
hdl/sample_rank_engine.sv
tb/sv/testbench.sv
